[hw/rtl/dma_usb_buffer_ownership_ring_core_macros.svh]
// Assertion macros for the buffer ownership ring
`ifndef DMA_USB_BUFFER_OWNERSHIP_RING_CORE_MACROS_SVH
`define DMA_USB_BUFFER_OWNERSHIP_RING_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DUBR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define DUBR_ASSERT_R(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DUBR_ASSERT(lbl, clk, rst_n, prop)
`define DUBR_ASSERT_R(lbl, clk, prop)
`endif
`endif

[hw/rtl/dubr_pkg.sv]
// Package: types and constants of the buffer ownership ring
`default_nettype none
package dubr_pkg;
  localparam int unsigned MaxSlotsDefault = 16;

  typedef enum logic [3:0] {
    F_REINIT = 4'd0, F_ACQUIRE = 4'd1, F_COMPLETE = 4'd2, F_PREPARE = 4'd3,
    F_QUEUE = 4'd4, F_ACTIVATE = 4'd5, F_RETIRE = 4'd6, F_CANCEL = 4'd7,
    F_DROP = 4'd8
  } func_t;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BADARG = 3'd1;
  localparam logic [2:0] ST_STALE = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_BLOCK = 3'd4;

  localparam logic [2:0] S_FREE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_RAW = 3'd2;
  localparam logic [2:0] S_USB = 3'd3;
  localparam logic [2:0] S_QUEUED = 3'd4;
  localparam logic [2:0] S_ACTIVE = 3'd5;

  localparam logic [1:0] CFG_ACTIVE = 2'd0;
  localparam logic [1:0] CFG_CAP = 2'd1;
  localparam logic [1:0] CFG_GEN = 2'd2;

  typedef struct packed {
    logic [3:0]  func;
    logic [3:0]  slot;
    logic [31:0] byte_count;
    logic [31:0] samples;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  granted_slot;
    logic [2:0]  slot_state_now;
    logic [31:0] slot_bytes_now;
    logic [31:0] slot_samples_now;
    logic [63:0] slot_first_seq;
    logic [63:0] sequence_now;
    logic [63:0] dropped_now;
    logic [31:0] illegal_now;
    logic [31:0] backpressure_now;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item
    logic decide;   // evaluate loaded item (ops other than acquire and a valid reinit)
    logic wipe;     // clear one slot at the sweep index
    logic probe;    // test one slot at the search index
    logic reduce;   // subtract the ring size from an out-of-range search index
    logic finish;   // build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_reinit_ok;
    logic is_acquire;
    logic sweep_last;
    logic probe_hit;
    logic probe_last;
    logic idx_wrap;
  } dp_sts_t;
endpackage
`default_nettype wire

[hw/rtl/dubr_if.sv]
// Valid/ready channel interface
`default_nettype none
interface dubr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/dubr_ctrl.sv]
// Controller state machine of the buffer ownership ring
`default_nettype none
module dubr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dubr_pkg::dp_cmd_t    cmd,
  input  wire dubr_pkg::dp_sts_t sts
);
  import dubr_pkg::*;

  typedef enum logic [2:0] {IDLE, DECIDE, SWEEP, SEARCH, FINISH, HOLD} state_t;
  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    in_ready = (state_r == IDLE);
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = DECIDE;
        end
      end
      DECIDE: begin
        if (sts.is_reinit_ok) state_nxt = SWEEP;
        else if (sts.is_acquire) state_nxt = SEARCH;
        else begin
          cmd.decide = 1'b1;
          state_nxt = FINISH;
        end
      end
      SWEEP: begin
        cmd.wipe = 1'b1;
        if (sts.sweep_last) state_nxt = FINISH;
      end
      SEARCH: begin
        if (sts.idx_wrap) cmd.reduce = 1'b1;
        else begin
          cmd.probe = 1'b1;
          if (sts.probe_hit || sts.probe_last) state_nxt = FINISH;
        end
      end
      FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

[hw/rtl/dubr_dp.sv]
// Datapath of the buffer ownership ring: slot table, counters, result register
`default_nettype none
module dubr_dp #(
  parameter int unsigned MAX_SLOTS = dubr_pkg::MaxSlotsDefault,
  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dubr_pkg::in_item_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata,
  input  wire dubr_pkg::dp_cmd_t cmd,
  output dubr_pkg::dp_sts_t      sts,
  output dubr_pkg::out_item_t    out_data
);
  import dubr_pkg::*;

  localparam logic [8:0] MaxN = 9'(MAX_SLOTS);

  logic [4:0]  act_r;
  logic [31:0] cap_r, gen_r;
  logic [2:0]  st_r   [MAX_SLOTS];
  logic [31:0] sgen_r [MAX_SLOTS];
  logic [31:0] sbyt_r [MAX_SLOTS];
  logic [31:0] ssmp_r [MAX_SLOTS];
  logic [63:0] sseq_r [MAX_SLOTS];
  logic [IW-1:0] cursor_r;
  logic [63:0] seq_r, drop_r;
  logic [31:0] ill_r, bp_r;
  in_item_t    it_r;
  logic [IW-1:0] idx_r;     // sweep or search index
  logic [8:0]  cnt_r;       // probes done
  logic [2:0]  status_r;
  logic        show_r;
  logic [IW-1:0] shown_r;
  out_item_t   res_r;

  logic [8:0] n;
  assign n = ({4'd0, act_r} > MaxN) ? MaxN : {4'd0, act_r};

  logic [IW-1:0] slot_i, nm1;
  logic          slot_ok;
  assign slot_i = IW'(it_r.slot);
  assign slot_ok = ({5'd0, it_r.slot} < n);
  assign nm1 = IW'(n - 9'd1);

  logic reinit_ok;
  assign reinit_ok = (it_r.func == F_REINIT) && (act_r != 5'd0) &&
                     ({4'd0, act_r} <= MaxN) && (cap_r != 32'd0);

  logic [8:0] idx_ext;
  assign idx_ext = {{(9-IW){1'b0}}, idx_r};

  assign sts.is_reinit_ok = reinit_ok;
  assign sts.is_acquire = (it_r.func == F_ACQUIRE);
  assign sts.sweep_last = (idx_ext == MaxN - 9'd1);
  assign sts.probe_hit = (n != 9'd0) && (st_r[idx_r] == S_FREE);
  assign sts.probe_last = (cnt_r + 9'd1 >= n);
  assign sts.idx_wrap = (n != 9'd0) && (idx_ext >= n);

  logic [2:0] from_s, to_s;
  always_comb begin
    from_s = S_FREE;
    to_s = S_FREE;
    case (it_r.func)
      F_COMPLETE: begin from_s = S_FILL;   to_s = S_RAW;    end
      F_PREPARE:  begin from_s = S_RAW;    to_s = S_USB;    end
      F_QUEUE:    begin from_s = S_USB;    to_s = S_QUEUED; end
      F_ACTIVATE: begin from_s = S_QUEUED; to_s = S_ACTIVE; end
      F_RETIRE:   begin from_s = S_ACTIVE; to_s = S_FREE;   end
      default:    begin from_s = S_FREE;   to_s = S_FREE;   end
    endcase
  end

  logic gen_eq;
  logic [2:0] cur_st;
  assign gen_eq = (sgen_r[slot_i] == gen_r);
  assign cur_st = st_r[slot_i];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 5'd16;
      cap_r <= 32'd16384;
      gen_r <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        st_r[i] <= S_FREE;
        sgen_r[i] <= '0;
        sbyt_r[i] <= '0;
        ssmp_r[i] <= '0;
        sseq_r[i] <= '0;
      end
      cursor_r <= '0;
      seq_r <= '0;
      drop_r <= '0;
      ill_r <= '0;
      bp_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACTIVE: act_r <= cfg_wdata[4:0];
          CFG_CAP:    cap_r <= cfg_wdata;
          CFG_GEN:    gen_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        it_r <= in_data;
        show_r <= 1'b0;
        shown_r <= '0;
        status_r <= ST_OK;
        cnt_r <= '0;
        idx_r <= (in_data.func == F_ACQUIRE) ? cursor_r : '0;
      end
      if (cmd.decide) begin
        case (it_r.func)
          F_REINIT: status_r <= ST_BADARG;
          F_COMPLETE, F_PREPARE, F_QUEUE, F_ACTIVATE, F_RETIRE: begin
            if (!slot_ok || ((it_r.func == F_COMPLETE || it_r.func == F_PREPARE)
                && it_r.byte_count > cap_r)) begin
              status_r <= ST_BADARG;
            end else begin
              show_r <= 1'b1;
              shown_r <= slot_i;
              if (!gen_eq) status_r <= ST_STALE;
              else if (cur_st != from_s) begin
                status_r <= ST_ILLEGAL;
                ill_r <= ill_r + 32'd1;
              end else begin
                st_r[slot_i] <= to_s;
                if (it_r.func == F_COMPLETE) begin
                  sbyt_r[slot_i] <= it_r.byte_count;
                  ssmp_r[slot_i] <= it_r.samples;
                  seq_r <= seq_r + {32'd0, it_r.samples};
                end else if (it_r.func == F_PREPARE) begin
                  sbyt_r[slot_i] <= it_r.byte_count;
                end
              end
            end
          end
          F_CANCEL: begin
            if (!slot_ok) status_r <= ST_BADARG;
            else begin
              show_r <= 1'b1;
              shown_r <= slot_i;
              if (cur_st != S_QUEUED && cur_st != S_ACTIVE) begin
                status_r <= ST_ILLEGAL;
                ill_r <= ill_r + 32'd1;
              end else if (!gen_eq) status_r <= ST_STALE;
              else st_r[slot_i] <= S_FREE;
            end
          end
          F_DROP: begin
            if (it_r.samples == 32'd0) status_r <= ST_BADARG;
            else begin
              drop_r <= drop_r + {32'd0, it_r.samples};
              seq_r <= seq_r + {32'd0, it_r.samples};
            end
          end
          default: status_r <= ST_BADARG;
        endcase
      end
      if (cmd.wipe) begin
        st_r[idx_r] <= S_FREE;
        sgen_r[idx_r] <= (idx_ext < n) ? gen_r : 32'd0;
        sbyt_r[idx_r] <= '0;
        ssmp_r[idx_r] <= '0;
        sseq_r[idx_r] <= '0;
        idx_r <= idx_r + IW'(1);
        if (sts.sweep_last) begin
          cursor_r <= '0;
          seq_r <= '0;
          drop_r <= '0;
          ill_r <= '0;
          bp_r <= '0;
        end
      end
      if (cmd.reduce) begin
        idx_r <= IW'(idx_ext - n);
      end
      if (cmd.probe) begin
        if (sts.probe_hit) begin
          st_r[idx_r] <= S_FILL;
          sbyt_r[idx_r] <= '0;
          ssmp_r[idx_r] <= '0;
          sseq_r[idx_r] <= seq_r;
          cursor_r <= (idx_r == nm1) ? '0 : idx_r + IW'(1);
          show_r <= 1'b1;
          shown_r <= idx_r;
        end else begin
          idx_r <= (idx_r == nm1) ? '0 : idx_r + IW'(1);
          cnt_r <= cnt_r + 9'd1;
          if (sts.probe_last) begin
            status_r <= ST_BLOCK;
            bp_r <= bp_r + 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r.status <= status_r;
      res_r.granted_slot <= (show_r && it_r.func == F_ACQUIRE) ? 4'(shown_r) : 4'd0;
      res_r.slot_state_now <= show_r ? st_r[shown_r] : 3'd0;
      res_r.slot_bytes_now <= show_r ? sbyt_r[shown_r] : 32'd0;
      res_r.slot_samples_now <= show_r ? ssmp_r[shown_r] : 32'd0;
      res_r.slot_first_seq <= show_r ? sseq_r[shown_r] : 64'd0;
      res_r.sequence_now <= seq_r;
      res_r.dropped_now <= drop_r;
      res_r.illegal_now <= ill_r;
      res_r.backpressure_now <= bp_r;
    end
  end

  assign out_data = res_r;
endmodule
`default_nettype wire

[hw/rtl/dma_usb_buffer_ownership_ring_core.sv]
// Top level of the buffer ownership ring
// Usage:
//  in  : valid/ready channel carrying func, slot, byte_count and samples.
//  out : valid/ready channel carrying one result per input transaction.
//  cfg : write port; index 0 active_slots, 1 slot_capacity, 2 ring_generation.
//  Steps from acceptance to a valid result: a transition, drop or rejected
//  operation is decided and then registered; an acquire probes slots one at
//  a time from the cursor (at most n) and, after active_slots was lowered,
//  first subtracts n until the cursor folds back into the ring; a reinit
//  covers all MAX_SLOTS slots (one slot rewritten per cycle).
//  The block handles one transaction at a time: a new input is taken only
//  after the previous result is in the output register.
//  The output register holds its result until taken; a stalled receiver
//  holds the block in its finishing state with in_ready low.
//  Reset (rst_n low, synchronous) frees all slots, clears counters and the
//  cursor and restores the registers to 16, 16384 and 0. No clearing pass.
`default_nettype none
`include "dma_usb_buffer_ownership_ring_core_macros.svh"
module dma_usb_buffer_ownership_ring_core #(
  parameter int unsigned MAX_SLOTS = dubr_pkg::MaxSlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dubr_if.sink             in_ch,
  dubr_if.source           out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import dubr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dubr_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  dubr_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk, .rst_n,
    .in_data(in_ch.data),
    .cfg_we, .cfg_index, .cfg_wdata,
    .cmd, .sts,
    .out_data(out_ch.data)
  );

  `DUBR_ASSERT(a_one_cmd, clk, rst_n, $onehot0(cmd))
  `DUBR_ASSERT(a_fin_valid, clk, rst_n, cmd.finish |=> out_ch.valid)
  `DUBR_ASSERT(a_load_busy, clk, rst_n, cmd.load |=> !in_ch.ready)
endmodule
`default_nettype wire
